/* hdl/slx_pkg.sv */
// Shared types and constants for the snapshot interpolation block.
package slx_pkg;

  // Query classification computed by the datapath
  localparam logic [1:0] KIND_HOLD   = 2'd0;
  localparam logic [1:0] KIND_EXTRAP = 2'd1;
  localparam logic [1:0] KIND_DIVIDE = 2'd2;
  localparam logic [1:0] KIND_ZERO   = 2'd3;

  // Result origin codes
  localparam logic [1:0] HOW_HOLD   = 2'd0;
  localparam logic [1:0] HOW_INTERP = 2'd1;
  localparam logic [1:0] HOW_EXTRAP = 2'd2;

  // Input function codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [15:0] LIMIT_RESET = 16'd3277;
  localparam int          DIV_STEPS   = 17;
  localparam logic [16:0] T_ONE       = 17'h10000;

  typedef struct packed {
    logic       store;
    logic       capture;
    logic       classify;
    logic       div_step;
    logic       div_first;
    logic       div_last;
    logic       mul;
    logic       acc;
    logic [1:0] lane;
    logic       publish;
  } slx_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
  } slx_stat_t;

endpackage

/* hdl/slx_ctrl.sv */
// Controller state machine for the snapshot interpolation block.
module slx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_ready,
  input  slx_pkg::slx_stat_t  stat,
  output slx_pkg::slx_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       extrap_r, extrap_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    extrap_nxt = extrap_r;
    cmd        = '0;
    cmd.lane   = cnt_r[1:0];
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == slx_pkg::FUNC_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_CLASS;
          end
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        cnt_nxt      = '0;
        extrap_nxt   = 1'b0;
        case (stat.kind)
          slx_pkg::KIND_HOLD:   state_nxt = S_DONE;
          slx_pkg::KIND_EXTRAP: begin
            extrap_nxt = 1'b1;
            state_nxt  = S_MUL;
          end
          slx_pkg::KIND_DIVIDE: state_nxt = S_DIV;
          default:              state_nxt = S_MUL;
        endcase
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cmd.div_last  = (cnt_r == 5'(slx_pkg::DIV_STEPS - 1));
        if (cmd.div_last) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (cnt_r[1:0] == (extrap_r ? 2'd1 : 2'd3)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      extrap_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      extrap_r    <= extrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < 5'(slx_pkg::DIV_STEPS)))
    else $error("divider step count out of range");

  a_extrap_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && extrap_r) |-> (cnt_r < 5'd2))
    else $error("extrapolation touched a paddle lane");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result shown without finishing a query");

endmodule

/* hdl/slx_dp.sv */
// Datapath: snapshot storage, query classification, divider and shared multiplier.
module slx_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  slx_pkg::slx_cmd_t   cmd,
  output slx_pkg::slx_stat_t  stat,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic [31:0]         in_time_value,
  input  logic signed [31:0]  in_ball_x,
  input  logic signed [31:0]  in_ball_y,
  input  logic signed [31:0]  in_ball_speed_x,
  input  logic signed [31:0]  in_ball_speed_y,
  input  logic signed [31:0]  in_paddle_x,
  input  logic signed [31:0]  in_paddle_y,
  output logic signed [31:0]  out_ball_x,
  output logic signed [31:0]  out_ball_y,
  output logic signed [31:0]  out_paddle_x,
  output logic signed [31:0]  out_paddle_y,
  output logic [1:0]          out_how_made
);

  logic               have_r;
  logic [31:0]        prev_time_r, cur_time_r, tq_r;
  logic signed [31:0] prev_pos_r [4];
  logic signed [31:0] cur_pos_r  [4];
  logic signed [31:0] speed_r    [2];
  logic signed [31:0] res_r      [4];
  logic [1:0]         how_r;
  logic [15:0]        limit_r;
  logic [32:0]        rem_r;
  logic [16:0]        quo_r, factor_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] obx_r, oby_r, opx_r, opy_r;
  logic [1:0]         ohow_r;

  logic [31:0]        span, ahead, over;
  logic [32:0]        trial, rem_nxt;
  logic               ge;
  logic [16:0]        quo_nxt;
  logic signed [31:0] in_pos [4];
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic signed [31:0] base;
  logic signed [35:0] sum;
  logic signed [31:0] acc_val;
  logic               fits;

  assign in_pos[0] = in_ball_x;
  assign in_pos[1] = in_ball_y;
  assign in_pos[2] = in_paddle_x;
  assign in_pos[3] = in_paddle_y;

  assign span  = cur_time_r - prev_time_r;
  assign ahead = tq_r - prev_time_r;
  assign over  = tq_r - cur_time_r;

  always_comb begin
    if (!have_r || !(cur_time_r > prev_time_r)) begin
      stat.kind = slx_pkg::KIND_HOLD;
    end else if (tq_r > cur_time_r) begin
      stat.kind = (over > {16'd0, limit_r}) ? slx_pkg::KIND_HOLD : slx_pkg::KIND_EXTRAP;
    end else if (tq_r > prev_time_r) begin
      stat.kind = slx_pkg::KIND_DIVIDE;
    end else begin
      stat.kind = slx_pkg::KIND_ZERO;
    end
  end

  // restoring divider: first step compares without shifting (quotient bit 16)
  assign trial   = cmd.div_first ? rem_r : {rem_r[31:0], 1'b0};
  assign ge      = (trial >= {1'b0, span});
  assign rem_nxt = ge ? (trial - {1'b0, span}) : trial;
  assign quo_nxt = {quo_r[15:0], ge};

  always_comb begin
    if (how_r == slx_pkg::HOW_EXTRAP) begin
      mul_a = {speed_r[cmd.lane[0]][31], speed_r[cmd.lane[0]]};
      base  = cur_pos_r[cmd.lane];
    end else begin
      mul_a = {cur_pos_r[cmd.lane][31], cur_pos_r[cmd.lane]}
            - {prev_pos_r[cmd.lane][31], prev_pos_r[cmd.lane]};
      base  = prev_pos_r[cmd.lane];
    end
  end

  assign mul_b = $signed({1'b0, factor_r});
  assign prod  = mul_a * mul_b;

  // floor of the product over 65536, then add and saturate
  assign sum  = {{4{base[31]}}, base} + {prod_r[50], prod_r[50:16]};
  assign fits = (sum[35:31] == 5'b00000) || (sum[35:31] == 5'b11111);
  always_comb begin
    if (fits) begin
      acc_val = sum[31:0];
    end else if (sum[35]) begin
      acc_val = 32'sh8000_0000;
    end else begin
      acc_val = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      prev_time_r <= '0;
      cur_time_r  <= '0;
      limit_r     <= slx_pkg::LIMIT_RESET;
      for (int i = 0; i < 4; i++) begin
        prev_pos_r[i] <= '0;
        cur_pos_r[i]  <= '0;
      end
      speed_r[0] <= '0;
      speed_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.store) begin
        have_r     <= 1'b1;
        cur_time_r <= in_time_value;
        speed_r[0] <= in_ball_speed_x;
        speed_r[1] <= in_ball_speed_y;
        prev_time_r <= have_r ? cur_time_r : in_time_value;
        for (int i = 0; i < 4; i++) begin
          cur_pos_r[i]  <= in_pos[i];
          prev_pos_r[i] <= have_r ? cur_pos_r[i] : in_pos[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tq_r <= in_time_value;
    end
    if (cmd.classify) begin
      rem_r <= {1'b0, ahead};
      quo_r <= '0;
      case (stat.kind)
        slx_pkg::KIND_HOLD: begin
          how_r <= slx_pkg::HOW_HOLD;
          for (int i = 0; i < 4; i++) res_r[i] <= cur_pos_r[i];
        end
        slx_pkg::KIND_EXTRAP: begin
          how_r    <= slx_pkg::HOW_EXTRAP;
          factor_r <= over[16:0];
          for (int i = 0; i < 4; i++) res_r[i] <= cur_pos_r[i];
        end
        slx_pkg::KIND_DIVIDE: begin
          how_r <= slx_pkg::HOW_INTERP;
        end
        default: begin
          how_r    <= slx_pkg::HOW_INTERP;
          factor_r <= '0;
        end
      endcase
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cmd.div_last) begin
        factor_r <= (quo_nxt > slx_pkg::T_ONE) ? slx_pkg::T_ONE : quo_nxt;
      end
    end
    if (cmd.mul) begin
      prod_r <= prod;
    end
    if (cmd.acc) begin
      res_r[cmd.lane] <= acc_val;
    end
    if (cmd.publish) begin
      obx_r  <= res_r[0];
      oby_r  <= res_r[1];
      opx_r  <= res_r[2];
      opy_r  <= res_r[3];
      ohow_r <= how_r;
    end
  end

  assign out_ball_x   = obx_r;
  assign out_ball_y   = oby_r;
  assign out_paddle_x = opx_r;
  assign out_paddle_y = opy_r;
  assign out_how_made = ohow_r;

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !have_r |-> (cur_time_r == '0 && cur_pos_r[0] == '0 && cur_pos_r[1] == '0
                 && cur_pos_r[2] == '0 && cur_pos_r[3] == '0))
    else $error("newer slot not clear before first snapshot");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |=> (factor_r <= slx_pkg::T_ONE))
    else $error("interpolation factor above one");

  a_lerp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && how_r == slx_pkg::HOW_INTERP) |-> fits)
    else $error("interpolation left the span of the snapshots");

endmodule

/* hdl/snapshot_lerp_extrapolate.sv */
// Top level of the snapshot interpolation and dead-reckoning block.
//
// Usage:
//   Input channel (in_valid/in_ready): in_func = 0 stores a snapshot (time,
//   ball position and speed, paddle position) and gives no result; in_func = 1
//   is a query at render time in_time_value and gives exactly one result.
//   Result channel (out_valid/out_ready): four positions plus out_how_made
//   (0 newer snapshot held, 1 interpolated, 2 extrapolated by ball speed).
//   Config channel (cfg_valid/cfg_ready): cfg_extrap_limit, always ready;
//   write it only while no query is in flight.
// Sequence:
//   A store is written as it is taken. A held query goes straight to the
//   result; an extrapolation runs the single shared 33x18 multiplier over
//   the two ball lanes and an interpolation over all four, first running
//   the 17-step restoring divider unless at or before the older snapshot.
//   The input side takes a new transfer while a result still waits in the
//   output register; a query that finishes with the output still stalled
//   holds until out_ready frees the register.
// Reset: rst_n (synchronous, active low) empties both snapshot slots, zeroes
//   the stored positions and sets the limit to 3277 (about 50 ms).
module snapshot_lerp_extrapolate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [31:0]        in_time_value,
  input  logic signed [31:0] in_ball_x,
  input  logic signed [31:0] in_ball_y,
  input  logic signed [31:0] in_ball_speed_x,
  input  logic signed [31:0] in_ball_speed_y,
  input  logic signed [31:0] in_paddle_x,
  input  logic signed [31:0] in_paddle_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_ball_x,
  output logic signed [31:0] out_ball_y,
  output logic signed [31:0] out_paddle_x,
  output logic signed [31:0] out_paddle_y,
  output logic [1:0]         out_how_made,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_extrap_limit
);

  slx_pkg::slx_cmd_t  cmd;
  slx_pkg::slx_stat_t stat;

  // the limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  slx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slx_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_extrap_limit),
    .in_time_value   (in_time_value),
    .in_ball_x       (in_ball_x),
    .in_ball_y       (in_ball_y),
    .in_ball_speed_x (in_ball_speed_x),
    .in_ball_speed_y (in_ball_speed_y),
    .in_paddle_x     (in_paddle_x),
    .in_paddle_y     (in_paddle_y),
    .out_ball_x      (out_ball_x),
    .out_ball_y      (out_ball_y),
    .out_paddle_x    (out_paddle_x),
    .out_paddle_y    (out_paddle_y),
    .out_how_made    (out_how_made)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the snapshot interpolation / dead-reckoning block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int SETTLE_CYCLES   = 40;     // longest query is an interpolation with a division
  localparam int PRESSURE_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 660;    // per phase, three phases
  localparam int REPORT_LIMIT    = 10;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  // One transfer on the input channel
  typedef struct {
    logic               func;
    logic [31:0]        tv;
    logic signed [31:0] bx, by, sx, sy, px, py;
  } game_item_t;

  // Positions the block should return for one query
  typedef struct {
    logic signed [31:0] bx, by, px, py;
    logic [1:0]         how;
  } render_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic               in_func         = slx_pkg::FUNC_STORE;
  logic [31:0]        in_time_value   = '0;
  logic signed [31:0] in_ball_x       = '0;
  logic signed [31:0] in_ball_y       = '0;
  logic signed [31:0] in_ball_speed_x = '0;
  logic signed [31:0] in_ball_speed_y = '0;
  logic signed [31:0] in_paddle_x     = '0;
  logic signed [31:0] in_paddle_y     = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic signed [31:0] out_ball_x, out_ball_y, out_paddle_x, out_paddle_y;
  logic [1:0]         out_how_made;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_extrap_limit = '0;

  snapshot_lerp_extrapolate uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_time_value    (in_time_value),
    .in_ball_x        (in_ball_x),
    .in_ball_y        (in_ball_y),
    .in_ball_speed_x  (in_ball_speed_x),
    .in_ball_speed_y  (in_ball_speed_y),
    .in_paddle_x      (in_paddle_x),
    .in_paddle_y      (in_paddle_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ball_x       (out_ball_x),
    .out_ball_y       (out_ball_y),
    .out_paddle_x     (out_paddle_x),
    .out_paddle_y     (out_paddle_y),
    .out_how_made     (out_how_made),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_extrap_limit (cfg_extrap_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the two snapshot slots and the limit.
  // Index 0 ball x, 1 ball y, 2 paddle x, 3 paddle y.
  // ---------------------------------------------------------------------------
  logic               snap_seen   = 1'b0;
  logic [31:0]        older_time  = '0;
  logic [31:0]        newer_time  = '0;
  logic signed [31:0] older_pos[4] = '{default: '0};
  logic signed [31:0] newer_pos[4] = '{default: '0};
  logic signed [31:0] newer_speed[2] = '{default: '0};
  logic [15:0]        limit_reg   = slx_pkg::LIMIT_RESET;

  game_item_t     item_queue[$];
  render_result_t expected_positions[$];

  // Stimulus-side view of the snapshot times, used only to aim queries and stores
  logic        gen_seen  = 1'b0;
  logic [31:0] gen_older = '0;
  logic [31:0] gen_newer = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic pressure_armed = 1'b0;
  logic pressure_done  = 1'b0;
  int   hold_left      = 0;

  int mismatches = 0;
  int stores_taken = 0;
  int queries_taken = 0;
  int results_seen = 0;
  int how_count[3] = '{default: 0};

  function automatic logic signed [31:0] sat_word(input longint signed v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[31:0];
  endfunction

  // Shift the newer slot down and latch the new snapshot; the first one
  // after reset lands in both slots.
  function automatic void take_snapshot(input game_item_t it);
    older_pos  = newer_pos;
    older_time = newer_time;
    newer_pos[0]   = it.bx;
    newer_pos[1]   = it.by;
    newer_pos[2]   = it.px;
    newer_pos[3]   = it.py;
    newer_speed[0] = it.sx;
    newer_speed[1] = it.sy;
    newer_time     = it.tv;
    if (!snap_seen) begin
      older_pos  = newer_pos;
      older_time = newer_time;
      snap_seen  = 1'b1;
    end
  endfunction

  // Positions at render time tr, bit exact with floor rounding.
  function automatic render_result_t render_at(input logic [31:0] tr);
    render_result_t     r;
    logic signed [31:0] res[4];
    logic [31:0]        overshoot, span, offset;
    longint signed      acc;
    longint unsigned    frac;
    res = newer_pos;
    r.how = slx_pkg::HOW_HOLD;
    if (snap_seen && newer_time > older_time) begin
      if (tr > newer_time) begin
        overshoot = tr - newer_time;
        if (overshoot <= {16'd0, limit_reg}) begin
          // dead reckoning on the ball only, paddle stays put
          for (int i = 0; i < 2; i++) begin
            acc = longint'(newer_speed[i]) * longint'(overshoot);
            acc = acc >>> 16;
            res[i] = sat_word(longint'(newer_pos[i]) + acc);
          end
          r.how = slx_pkg::HOW_EXTRAP;
        end
      end else begin
        span   = newer_time - older_time;
        offset = tr - older_time;
        frac   = 0;
        if (tr > older_time) frac = (longint'(offset) << 16) / longint'(span);
        if (frac > 65536) frac = 65536;
        for (int i = 0; i < 4; i++) begin
          acc = (longint'(newer_pos[i]) - longint'(older_pos[i])) * longint'(frac);
          acc = acc >>> 16;
          res[i] = sat_word(longint'(older_pos[i]) + acc);
        end
        r.how = slx_pkg::HOW_INTERP;
      end
    end
    r.bx = res[0];
    r.by = res[1];
    r.px = res[2];
    r.py = res[3];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: present the next pending item once the previous transfer
  // is done, with random gaps. Predict on every accepted transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    game_item_t nxt;
    game_item_t seen;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen.func = in_func;
        seen.tv   = in_time_value;
        seen.bx   = in_ball_x;
        seen.by   = in_ball_y;
        seen.sx   = in_ball_speed_x;
        seen.sy   = in_ball_speed_y;
        seen.px   = in_paddle_x;
        seen.py   = in_paddle_y;
        if (seen.func == slx_pkg::FUNC_STORE) begin
          take_snapshot(seen);
          stores_taken++;
        end else begin
          expected_positions.push_back(render_at(seen.tv));
          queries_taken++;
        end
      end
      // hold the payload until the transfer happens
      if (!in_valid || in_ready) begin
        if (item_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = item_queue.pop_front();
          in_valid        <= 1'b1;
          in_func         <= nxt.func;
          in_time_value   <= nxt.tv;
          in_ball_x       <= nxt.bx;
          in_ball_y       <= nxt.by;
          in_ball_speed_x <= nxt.sx;
          in_ball_speed_y <= nxt.sy;
          in_paddle_x     <= nxt.px;
          in_paddle_y     <= nxt.py;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest expectation and
  // throttle out_ready at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    render_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_how_made <= slx_pkg::HOW_EXTRAP) how_count[out_how_made]++;
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result: ball %0d,%0d paddle %0d,%0d how %0d",
                     $realtime, out_ball_x, out_ball_y, out_paddle_x, out_paddle_y,
                     out_how_made);
        end else begin
          e = expected_positions.pop_front();
          if (out_ball_x !== e.bx || out_ball_y !== e.by || out_paddle_x !== e.px ||
              out_paddle_y !== e.py || out_how_made !== e.how) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("[%0t] mismatch: expected ball %0d,%0d paddle %0d,%0d how %0d",
                       $realtime, e.bx, e.by, e.px, e.py, e.how);
              $display("             actual   ball %0d,%0d paddle %0d,%0d how %0d",
                       out_ball_x, out_ball_y, out_paddle_x, out_paddle_y, out_how_made);
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off: once armed, keep out_ready low for a fixed span
  // so the output register fills and the block backs up its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_armed && !pressure_done) begin
      hold_left     <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] any_word();
    case ($urandom_range(5, 0))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return $signed($urandom_range(2000, 0)) - 32'sd1000;
      default: return $urandom;
    endcase
  endfunction

  // Queue an item and track the snapshot times the block will see.
  function automatic void push_item(input game_item_t it);
    if (it.func == slx_pkg::FUNC_STORE) begin
      gen_older = gen_seen ? gen_newer : it.tv;
      gen_newer = it.tv;
      gen_seen  = 1'b1;
    end
    item_queue.push_back(it);
  endfunction

  function automatic void push_fields(input logic f, input logic [31:0] tv,
                                      input logic signed [31:0] bx, by, sx, sy, px, py);
    game_item_t it;
    it.func = f;
    it.tv = tv;
    it.bx = bx;
    it.by = by;
    it.sx = sx;
    it.sy = sy;
    it.px = px;
    it.py = py;
    push_item(it);
  endfunction

  // Mostly queries aimed at the interesting windows around the two snapshots,
  // and stores with mostly rising times; a share of wild values as noise.
  function automatic game_item_t random_item();
    game_item_t  it;
    logic [31:0] span, lim;
    it.func = ($urandom_range(99, 0) < 30) ? slx_pkg::FUNC_STORE
                                           : slx_pkg::FUNC_QUERY;
    it.bx = any_word();
    it.by = any_word();
    it.sx = any_word();
    it.sy = any_word();
    it.px = any_word();
    it.py = any_word();
    lim  = {16'd0, limit_reg};
    span = gen_newer - gen_older;
    if (it.func == slx_pkg::FUNC_STORE) begin
      case ($urandom_range(9, 0))
        0:       it.tv = $urandom;
        1:       it.tv = gen_newer;
        2:       it.tv = gen_newer - $urandom_range(1000, 1);
        default: it.tv = gen_newer + $urandom_range(40000, 1);
      endcase
    end else begin
      case ($urandom_range(9, 0))
        0:       it.tv = $urandom;
        1:       it.tv = gen_older - $urandom_range(500, 0);
        2:       it.tv = gen_older;
        3:       it.tv = gen_newer;
        4, 5:    it.tv = gen_older + $urandom_range(span, 0);
        6, 7:    it.tv = gen_newer + $urandom_range(lim + 2, 1);
        8:       it.tv = gen_newer + lim + 1;
        default: it.tv = gen_newer + lim;
      endcase
    end
    return it;
  endfunction

  // Write the limit register; only called with nothing in flight.
  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_extrap_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every item went in and every result came out, then let a
  // trailing store settle.
  task automatic drain();
    while (item_queue.size() != 0 || in_valid || expected_positions.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_directed();
    logic [31:0] t_new;
    t_new = 32'd1000 + 32'd65536;
    // query before any snapshot: zeros, noise on the unused fields
    push_fields(slx_pkg::FUNC_QUERY, 32'd500, -1, -1, -1, -1, -1, -1);
    push_fields(slx_pkg::FUNC_STORE, 32'd1000, POS_MAX, POS_MIN, 0, 0, 0, -1);
    // one snapshot only: both slots share a time, hold
    push_fields(slx_pkg::FUNC_QUERY, 32'd1000, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd5000, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_STORE, t_new, POS_MIN, POS_MAX, POS_MAX, POS_MIN,
                POS_MAX, POS_MIN);
    // at and before the older snapshot: t = 0; then just past it and t = 0.5
    push_fields(slx_pkg::FUNC_QUERY, 32'd0, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd1000, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd1001, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd33768, 0, 0, 0, 0, 0, 0);
    // exactly at the newer snapshot: t = 1.0
    push_fields(slx_pkg::FUNC_QUERY, t_new, 0, 0, 0, 0, 0, 0);
    // just past, at the limit, one past the limit, far away
    push_fields(slx_pkg::FUNC_QUERY, t_new + 1, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, t_new + 3277, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, t_new + 3278, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    // ball near the rails with full speed: extrapolation saturates
    push_fields(slx_pkg::FUNC_STORE, t_new + 3000, POS_MAX - 10, POS_MIN + 10,
                POS_MAX, POS_MIN, 32'sd12345, -32'sd54321);
    push_fields(slx_pkg::FUNC_QUERY, t_new + 3000 + 3277, 0, 0, 0, 0, 0, 0);
    // newest time at the top of the range
    push_fields(slx_pkg::FUNC_STORE, 32'hFFFF_FFFF, 0, 0, -1, 1, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    // newer time behind the older one: hold
    push_fields(slx_pkg::FUNC_STORE, 32'd100, 7, -7, 0, 0, 3, -3);
    push_fields(slx_pkg::FUNC_QUERY, 32'd100, 0, 0, 0, 0, 0, 0);
    // tiny negative speeds: floor rounding goes toward minus infinity
    push_fields(slx_pkg::FUNC_STORE, 32'd101, 0, 0, -1, -32'sd65537, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd102, 0, 0, 0, 0, 0, 0);
    push_fields(slx_pkg::FUNC_QUERY, 32'd100, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic load_random(input int n);
    repeat (n) push_item(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles less than the receiver, default limit
    send_idle_pct = 26;
    recv_idle_pct = 58;
    load_directed();
    drain();

    // zero limit: any overshoot holds
    write_limit(16'd0);
    load_random(RANDOM_ITEMS);
    drain();

    // swap the idle rates, widest limit
    send_idle_pct = 58;
    recv_idle_pct = 26;
    write_limit(16'hFFFF);
    load_random(RANDOM_ITEMS);
    drain();

    // no idling, random limit, and one long receiver stall at the start of the stream
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(16'($urandom_range(65535, 0)));
    load_random(RANDOM_ITEMS);
    pressure_armed = 1'b1;
    drain();

    $display("Run covered %0d snapshot stores and %0d queries under four limit settings.",
             stores_taken, queries_taken);
    $display("Results by origin: %0d held, %0d interpolated, %0d extrapolated; %0d mismatches.",
             how_count[0], how_count[1], how_count[2], mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: count cycles and give up well past the slowest correct run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending.",
             cycles, expected_positions.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
